/* src/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* src/bpfm_pkg.sv */
package bpfm_pkg;

	localparam int DATA_W      = 8;
	localparam int OFFSET_W    = 16;
	localparam int LEN_CFG_W   = 5;
	localparam int REG_W       = 64;
	localparam int CFG_INDEX_W = 2;

	localparam int MAX_PATTERN_DEF  = 16;
	localparam int BUFFER_DEPTH_DEF = 65536;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LENGTH = 2'd0,
		CFG_PATTERN_LOW    = 2'd1,
		CFG_PATTERN_HIGH   = 2'd2
	} cfg_index_t;

	// Outcome of the window compare for one byte.
	typedef struct packed {
		logic                hit;      // full match ends at this byte
		logic                counted;  // position still below the buffer depth
		logic [OFFSET_W-1:0] start;    // match start offset, modulo 2^16
	} cmp_result_t;

endpackage

/* src/bpfm_compare.sv */
module bpfm_compare
	import bpfm_pkg::*;
#(
	parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int POS_W        = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic [DATA_W-1:0]    window [MAX_PATTERN],
	input  logic [LEN_CFG_W-1:0] pattern_length,
	input  logic [REG_W-1:0]     pattern_low_bytes,
	input  logic [REG_W-1:0]     pattern_high_bytes,
	input  logic [POS_W-1:0]     byte_position,
	output cmp_result_t          result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [DATA_W-1:0]      pat [MAX_PATTERN];
	logic [LEN_W-1:0]       len;
	logic [MAX_PATTERN-1:0] eq;
	logic [POS_W:0]         pos_inc;
	logic [POS_W:0]         len_ext;

	// Pattern bytes beyond the two registers read as zero.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
		if (j < 8) begin : g_low
			assign pat[j] = pattern_low_bytes[DATA_W*j +: DATA_W];
		end else if (j < 16) begin : g_high
			assign pat[j] = pattern_high_bytes[DATA_W*(j-8) +: DATA_W];
		end else begin : g_zero
			assign pat[j] = '0;
		end
	end

	always_comb begin
		if (int'(pattern_length) > MAX_PATTERN) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(pattern_length);
		end
	end

	// Window entry k (newest first) lines up with pattern byte len-1-k.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (k < int'(len)) begin
				eq[k] = (window[k] == pat[IDX_W'(int'(len) - 1 - k)]);
			end else begin
				eq[k] = 1'b1;
			end
		end
	end

	assign pos_inc = (POS_W+1)'(byte_position) + (POS_W+1)'(1);
	assign len_ext = (POS_W+1)'(len);

	always_comb begin
		result.counted = (byte_position < POS_W'(BUFFER_DEPTH));
		result.start   = OFFSET_W'(pos_inc - len_ext);
		if (!result.counted) begin
			result.hit = 1'b0;
		end else if (len == '0) begin
			// An empty pattern always starts at the first byte.
			result.hit   = (byte_position == '0);
			result.start = '0;
		end else begin
			result.hit = (pos_inc >= len_ext) && (&eq);
		end
	end

endmodule

/* src/byte_pattern_first_match_search.sv */
// Streaming first-match byte pattern search. Buffer bytes arrive one per word on the
// byte channel, the final byte of a buffer flagged by last_byte. The block compares
// the most recent bytes with the configured pattern (pattern_length bytes, byte 0 the
// oldest) and returns exactly one result word per buffer: found with the start offset
// as soon as the first match completes, or not-found with offset 0 on the last byte.
// Bytes after a match are swallowed until the last byte, after which the block rearms.
// A pattern length of zero matches at offset 0; lengths above MAX_PATTERN are clamped;
// a buffer shorter than the pattern gives not-found; bytes at positions at or beyond
// BUFFER_DEPTH are never compared. The block takes one byte every clock cycle while
// the byte channel does not stall. A byte passes through an input register and then
// a result register that offers the result it causes to the receiver; the full parallel
// window compare sits between those two registers. A result held by a stalling receiver
// keeps the next byte in the input register, and the byte channel stalls only while
// both registers are occupied. There is no start-up sweep after reset. Configuration
// must be written only while the block is idle, with no byte in flight.
`include "assert_macros.svh"

module byte_pattern_first_match_search
	import bpfm_pkg::*;
#(
	parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   write_enable,
	input  logic [CFG_INDEX_W-1:0] write_index,
	input  logic [REG_W-1:0]       write_data,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [DATA_W-1:0]      data_byte,
	input  logic                   last_byte,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   found,
	output logic [OFFSET_W-1:0]    match_offset
);

	localparam int POS_W = $clog2(BUFFER_DEPTH + 1);

	// Configuration registers.
	logic [LEN_CFG_W-1:0] pattern_length_q;
	logic [REG_W-1:0]     pattern_low_q;
	logic [REG_W-1:0]     pattern_high_q;

	// Input register.
	logic                 valid_s1;
	logic [DATA_W-1:0]    data_s1;
	logic                 last_s1;

	// Search state.
	logic [DATA_W-1:0]    window_q [MAX_PATTERN];
	logic [DATA_W-1:0]    window_next [MAX_PATTERN];
	logic [POS_W-1:0]     byte_position_q;
	logic                 match_reported_q;

	// Result register.
	logic                 result_valid_q;
	logic                 found_q;
	logic [OFFSET_W-1:0]  offset_q;

	logic                 proc;
	logic                 emit;
	logic                 accept;
	cmp_result_t          cmp;

	// The held word moves on whenever the result register is free or is being emptied.
	assign proc       = valid_s1 && (!result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !proc;
	assign accept     = byte_valid && !byte_stall;

	// After a reported match, bytes produce nothing, the last byte of the buffer included.
	assign emit = !match_reported_q && (cmp.hit || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_CFG_W'(1);
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
		end else if (write_enable) begin
			unique case (write_index)
				CFG_PATTERN_LENGTH: pattern_length_q <= write_data[LEN_CFG_W-1:0];
				CFG_PATTERN_LOW:    pattern_low_q    <= write_data;
				CFG_PATTERN_HIGH:   pattern_high_q   <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The window as it stands once the held byte has been shifted in.
	always_comb begin
		window_next[0] = data_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window_next[k] = window_q[k-1];
		end
	end

	bpfm_compare #(
		.MAX_PATTERN  (MAX_PATTERN),
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.POS_W        (POS_W)
	) u_compare (
		.window             (window_next),
		.pattern_length     (pattern_length_q),
		.pattern_low_bytes  (pattern_low_q),
		.pattern_high_bytes (pattern_high_q),
		.byte_position      (byte_position_q),
		.result             (cmp)
	);

	// Search state: the last byte of a buffer always rearms, whatever else happened.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= '0;
			end
			byte_position_q  <= '0;
			match_reported_q <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= '0;
				end
				byte_position_q  <= '0;
				match_reported_q <= 1'b0;
			end else if (!match_reported_q) begin
				window_q <= window_next;
				if (cmp.counted) begin
					byte_position_q <= byte_position_q + POS_W'(1);
				end
				if (cmp.hit) begin
					match_reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (proc) begin
			result_valid_q <= emit;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			found_q  <= cmp.hit;
			offset_q <= cmp.hit ? cmp.start : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

	// A not-found result always carries a zero offset.
	`ASSERT_IMPL(a_notfound_zero, clk, arst_n, result_valid_q && !found_q, offset_q == '0)
	// A byte swallowed after a match never leaves a result behind.
	`ASSERT_NEXT(a_absorb_silent, clk, arst_n, proc && match_reported_q, !result_valid_q)
	// A match ahead of the buffer end arms the swallowing of the remaining bytes.
	`ASSERT_NEXT(a_match_arms, clk, arst_n, proc && !match_reported_q && cmp.hit && !last_s1,
		match_reported_q)
	// The position count saturates at the buffer depth.
	`ASSERT_IMPL(a_pos_bound, clk, arst_n, 1'b1, byte_position_q <= POS_W'(BUFFER_DEPTH))

endmodule

/* tb/sv/first_match_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both word channels of the pattern search,
// keeps its own copy of the search state and compares every result word.
module first_match_checker
	import bpfm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   write_enable,
	input  logic [CFG_INDEX_W-1:0] write_index,
	input  logic [REG_W-1:0]       write_data,
	input  logic                   byte_valid,
	input  logic                   byte_stall,
	input  logic [DATA_W-1:0]      data_byte,
	input  logic                   last_byte,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic                   found,
	input  logic [OFFSET_W-1:0]    match_offset,
	output int                     mismatches,
	output int                     pending
);

	localparam int WINDOW = MAX_PATTERN_DEF;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} search_result_t;

	logic [DATA_W-1:0]    window_bytes [WINDOW];
	int unsigned          bytes_seen;
	logic                 match_held;
	logic [LEN_CFG_W-1:0] pattern_len;
	logic [REG_W-1:0]     pattern_lo;
	logic [REG_W-1:0]     pattern_hi;
	search_result_t       awaited_q [$];
	int                   fail_count;

	function automatic logic [DATA_W-1:0] pattern_byte(input int k);
		if (k < 8)
			return pattern_lo[8*k +: 8];
		return pattern_hi[8*(k-8) +: 8];
	endfunction

	function automatic void rearm_search();
		int k;
		for (k = 0; k < WINDOW; k++)
			window_bytes[k] = '0;
		bytes_seen = 0;
		match_held = 1'b0;
	endfunction

	// Advances the search by one byte; returns 1 when the byte produces a result.
	function automatic bit search_step(input logic [DATA_W-1:0] b, input logic ends,
			output search_result_t res);
		int n;
		int k;
		bit hit;
		logic [OFFSET_W-1:0] start_at;
		n = (pattern_len > WINDOW) ? WINDOW : int'(pattern_len);
		hit = 1'b0;
		start_at = '0;
		res = '0;
		if (match_held) begin
			if (ends)
				rearm_search();
			return 1'b0;
		end
		for (k = WINDOW - 1; k > 0; k--)
			window_bytes[k] = window_bytes[k-1];
		window_bytes[0] = b;
		if (bytes_seen < BUFFER_DEPTH_DEF) begin
			if (n == 0) begin
				hit = (bytes_seen == 0);
			end else if (bytes_seen + 1 >= n) begin
				hit = 1'b1;
				for (k = 0; k < n; k++)
					if (window_bytes[n-1-k] !== pattern_byte(k))
						hit = 1'b0;
				start_at = OFFSET_W'(bytes_seen + 1 - n);
			end
			bytes_seen++;
		end
		if (hit) begin
			res.found = 1'b1;
			res.offset = start_at;
			if (ends)
				rearm_search();
			else
				match_held = 1'b1;
			return 1'b1;
		end
		if (ends) begin
			rearm_search();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		search_result_t want;
		search_result_t predicted;
		if (!arst_n) begin
			rearm_search();
			pattern_len = LEN_CFG_W'(1);
			pattern_lo = '0;
			pattern_hi = '0;
			awaited_q.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// Results are compared before this edge's byte is predicted, so an
			// early result can never be matched against its own prediction.
			if (result_valid && !result_stall) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = awaited_q.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found is %b, expected %b",
							found, want.found));
					if (match_offset !== want.offset)
						report_mismatch($sformatf("match_offset is %0d, expected %0d",
							match_offset, want.offset));
				end
			end
			if (write_enable) begin
				case (write_index)
					CFG_PATTERN_LENGTH: pattern_len = write_data[LEN_CFG_W-1:0];
					CFG_PATTERN_LOW:    pattern_lo = write_data;
					CFG_PATTERN_HIGH:   pattern_hi = write_data;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall)
				if (search_step(data_byte, last_byte, predicted))
					awaited_q.push_back(predicted);
			mismatches <= fail_count;
			pending <= awaited_q.size();
		end
	end

endmodule

/* tb/sv/tb_byte_pattern_first_match_search.sv */
`timescale 1ns / 1ps

// Top of the testbench for the streaming first-match pattern search. It produces
// the clock, the single reset, the configuration writes and the byte words, and
// plays the receiver of result words. All prediction and comparison happens in
// the checker instantiated beside the block; this module only reads back its
// mismatch count and the number of result words still awaited.
module tb_byte_pattern_first_match_search;
	import bpfm_pkg::*;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	// A byte passes from the input register on to the result register, so the
	// settle wait is ample for absorbed bytes still in flight.
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 288;
	// The whole run sends under two thousand bytes, and the timeout leaves a wide
	// margin even with heavy stalling.
	localparam int TIMEOUT_NS    = 2_400_000;

	logic                   clk;
	logic                   arst_n;
	logic                   write_enable;
	logic [CFG_INDEX_W-1:0] write_index;
	logic [REG_W-1:0]       write_data;
	logic                   byte_valid;
	logic                   byte_stall;
	logic [DATA_W-1:0]      data_byte;
	logic                   last_byte;
	logic                   result_valid;
	logic                   result_stall;
	logic                   found;
	logic [OFFSET_W-1:0]    match_offset;

	int mismatches;
	int pending;

	// Stimulus bookkeeping: the pattern as last written, used only to shape
	// buffers so that matches and near misses are common.
	logic [DATA_W-1:0] cur_pat [MAX_PATTERN_DEF];
	int                eff_len;
	int                sender_idle_pct;
	int                receiver_stall_pct;
	logic              hold_req;
	logic              hold_off;

	byte_pattern_first_match_search u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.match_offset (match_offset)
	);

	first_match_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.match_offset (match_offset),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #6 clk = ~clk;

	// The receiver stalls at random with the current probability, and always
	// while the long hold-off is in force.
	always @(posedge clk) begin
		result_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
	end

	// The long hold-off counts its own cycles, so the sender keeps offering bytes
	// until the block is full and stalls the byte channel.
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Offers one byte word, with random idle cycles in front of it, and returns
	// at the edge where it is taken. The payload is held while stalled.
	task automatic send_byte(input logic [DATA_W-1:0] value, input logic is_last);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= value;
		last_byte <= is_last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
	endtask

	// Stops sending and waits until every awaited result word has arrived, then
	// lets absorbed bytes drain out of the pipeline.
	task automatic wait_idle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= val;
		@(posedge clk);
	endtask

	// Writes all three registers plus a stray write to the unused index. Only
	// called while the block is idle.
	task automatic load_pattern(input logic [REG_W-1:0] len_word,
			input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
		int k;
		write_reg(CFG_PATTERN_LENGTH, len_word);
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
		write_enable <= 1'b0;
		for (k = 0; k < 8; k++) begin
			cur_pat[k] = lo[8*k +: 8];
			cur_pat[k+8] = hi[8*k +: 8];
		end
		eff_len = (len_word[LEN_CFG_W-1:0] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF
			: int'(len_word[LEN_CFG_W-1:0]);
	endtask

	// Picks a length among the extremes and the ordinary range, with random
	// upper bits in the length word from time to time.
	task automatic random_pattern();
		logic [REG_W-1:0] len_word;
		logic [REG_W-1:0] lo;
		logic [REG_W-1:0] hi;
		case ($urandom_range(5))
			0: len_word = '0;
			1: len_word = REG_W'(MAX_PATTERN_DEF);
			2: len_word = REG_W'($urandom_range(MAX_PATTERN_DEF + 1, 31));
			default: len_word = REG_W'($urandom_range(1, MAX_PATTERN_DEF - 1));
		endcase
		if ($urandom_range(3) == 0)
			len_word[REG_W-1:LEN_CFG_W] = (REG_W - LEN_CFG_W)'({$urandom, $urandom});
		lo = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
		hi = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
		load_pattern(len_word, lo, hi);
	endtask

	// Half of the bytes come from the pattern itself, which gives partial
	// matches and overlapping candidates.
	function automatic logic [DATA_W-1:0] draw_byte();
		if (eff_len > 0 && $urandom_range(1) == 1)
			return cur_pat[$urandom_range(eff_len - 1)];
		return DATA_W'($urandom_range(255));
	endfunction

	// Mostly short buffers, a few longer ones; in most of them the pattern is
	// planted at a random place, sometimes ending on the last byte.
	task automatic send_random_buffer(inout int counted);
		logic [DATA_W-1:0] frame [$];
		int size;
		int at;
		int k;
		bit planted;
		size = ($urandom_range(9) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 20);
		for (k = 0; k < size; k++)
			frame.push_back(draw_byte());
		at = 0;
		planted = (eff_len > 0) && (size >= eff_len) && ($urandom_range(99) < 60);
		if (planted) begin
			at = $urandom_range(size - eff_len);
			for (k = 0; k < eff_len; k++)
				frame[at+k] = cur_pat[k];
		end
		for (k = 0; k < size; k++)
			send_byte(frame[k], k == size - 1);
		counted += size;
	endtask

	// One idling regime, run through three pattern settings. The block is idle
	// between settings, which is also where the sender waits for every result.
	task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
		int s;
		int counted;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (s = 0; s < 3; s++) begin
			wait_idle();
			random_pattern();
			if (with_hold && s == 1)
				hold_req = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS / 3)
				send_random_buffer(counted);
		end
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		write_enable = 1'b0;
		write_index = CFG_PATTERN_LENGTH;
		write_data = '0;
		byte_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		result_stall = 1'b0;
		hold_req = 1'b0;
		hold_off = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		eff_len = 1;
		for (k = 0; k < MAX_PATTERN_DEF; k++)
			cur_pat[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers as left by reset: one-byte pattern of zero, which matches on
		// the last byte of the buffer.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// Empty pattern: a hit at offset 0 on the first byte, the rest absorbed.
		wait_idle();
		load_pattern('0, {$urandom, $urandom}, {$urandom, $urandom});
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);

		// Three-byte pattern: a buffer shorter than the pattern gives not-found,
		// then a hit after a false start with one byte absorbed behind it.
		wait_idle();
		load_pattern(REG_W'(3), {$urandom, 8'h00, 24'h563412}, {$urandom, $urandom});
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'hAB, 1'b1);

		// Length above range is clamped to the full window of sixteen bytes,
		// matched exactly by a buffer of sixteen bytes.
		wait_idle();
		load_pattern({{(REG_W - LEN_CFG_W){1'b1}}, 5'd31}, {$urandom, $urandom},
			{$urandom, $urandom});
		for (k = 0; k < MAX_PATTERN_DEF; k++)
			send_byte(cur_pat[k], k == MAX_PATTERN_DEF - 1);

		// Random part in four idling regimes; the first one carries the long
		// receiver hold-off.
		run_phase(0, 0, 1'b1);
		run_phase(72, 0, 1'b0);
		run_phase(0, 72, 1'b0);
		run_phase(36, 36, 1'b0);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/bpfm_pkg.sv
src/bpfm_compare.sv
src/byte_pattern_first_match_search.sv
tb/sv/first_match_checker.sv
tb/sv/tb_byte_pattern_first_match_search.sv
